// File: hdl/fcfp_pkg.sv
// fcfp_pkg: shared widths, codes and decode helpers for the focuser command frame parser
// no dependencies; imported by focuser_command_frame_parser_core
package fcfp_pkg;

    localparam int C_MAX_PAYLOAD = 16;
    localparam int C_CNT_W       = $clog2(C_MAX_PAYLOAD + 1);

    localparam int C_BYTE_W   = 8;
    localparam int C_CODE_W   = 4;
    localparam int C_VALUE_W  = 16;
    localparam int C_STATUS_W = 2;
    localparam int C_RES_W    = C_CODE_W + C_VALUE_W + C_STATUS_W;
    localparam int C_TDATA_W  = ((C_RES_W + 7) / 8) * 8;

    typedef logic [C_BYTE_W-1:0]   t_byte;
    typedef logic [C_CODE_W-1:0]   t_code;
    typedef logic [C_VALUE_W-1:0]  t_value;
    typedef logic [C_STATUS_W-1:0] t_status;
    typedef logic [C_CNT_W-1:0]    t_count;

    // framing characters
    localparam t_byte C_CH_START = 8'h3A; // ':'
    localparam t_byte C_CH_END   = 8'h23; // '#'

    // command codes
    localparam t_code C_CMD_FQ    = 4'd0;
    localparam t_code C_CMD_GP    = 4'd1;
    localparam t_code C_CMD_SP    = 4'd2;
    localparam t_code C_CMD_GN    = 4'd3;
    localparam t_code C_CMD_SN    = 4'd4;
    localparam t_code C_CMD_FG    = 4'd5;
    localparam t_code C_CMD_GH    = 4'd6;
    localparam t_code C_CMD_SF    = 4'd7;
    localparam t_code C_CMD_SH    = 4'd8;
    localparam t_code C_CMD_GI    = 4'd9;
    localparam t_code C_CMD_GV    = 4'd10;
    localparam t_code C_CMD_GD    = 4'd11;
    localparam t_code C_CMD_SD    = 4'd12;
    localparam t_code C_CMD_GT    = 4'd13;
    localparam t_code C_CMD_GC    = 4'd14;
    localparam t_code C_CMD_UNREC = 4'd15;

    // frame status codes
    localparam t_status C_ST_OK      = 2'd0;
    localparam t_status C_ST_UNREC   = 2'd1;
    localparam t_status C_ST_BAD_LEN = 2'd2;
    localparam t_status C_ST_BAD_HEX = 2'd3;

    // expected payload lengths
    localparam t_count C_LEN_NONE  = t_count'(0);
    localparam t_count C_LEN_SPEED = t_count'(2);
    localparam t_count C_LEN_POS   = t_count'(4);

    function automatic t_code decode_pair(input t_byte a, input t_byte b);
        t_code code;
        code = C_CMD_UNREC;
        case (a)
            "F": begin
                case (b)
                    "Q":     code = C_CMD_FQ;
                    "G":     code = C_CMD_FG;
                    default: code = C_CMD_UNREC;
                endcase
            end
            "G": begin
                case (b)
                    "P":     code = C_CMD_GP;
                    "N":     code = C_CMD_GN;
                    "H":     code = C_CMD_GH;
                    "I":     code = C_CMD_GI;
                    "V":     code = C_CMD_GV;
                    "D":     code = C_CMD_GD;
                    "T":     code = C_CMD_GT;
                    "C":     code = C_CMD_GC;
                    default: code = C_CMD_UNREC;
                endcase
            end
            "S": begin
                case (b)
                    "P":     code = C_CMD_SP;
                    "N":     code = C_CMD_SN;
                    "F":     code = C_CMD_SF;
                    "H":     code = C_CMD_SH;
                    "D":     code = C_CMD_SD;
                    default: code = C_CMD_UNREC;
                endcase
            end
            default: code = C_CMD_UNREC;
        endcase
        return code;
    endfunction

    function automatic t_count expected_len(input t_code code);
        t_count len;
        if (code == C_CMD_SP || code == C_CMD_SN) begin
            len = C_LEN_POS;
        end else if (code == C_CMD_SD) begin
            len = C_LEN_SPEED;
        end else begin
            len = C_LEN_NONE;
        end
        return len;
    endfunction

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input t_byte c);
        logic [4:0] v;
        if (c inside {["0":"9"]}) begin
            v = 5'(c - 8'h30);
        end else if (c inside {["A":"F"]}) begin
            v = 5'(c - 8'h37);
        end else if (c inside {["a":"f"]}) begin
            v = 5'(c - 8'h57);
        end else begin
            v = 5'd16;
        end
        return v;
    endfunction

endpackage

// File: hdl/focuser_command_frame_parser_core.sv
// focuser_command_frame_parser_core: serial command frame parser, one character per word
// depends on fcfp_pkg
//
// Takes one received ASCII character per input word and parses frames of the form
// ':' opcode(2 chars) payload '#'. A ':' restarts the frame at any point; anything
// else outside a frame is dropped. On '#' one result word goes out with the command
// code, the hex payload value and a status (ok, unrecognized opcode, wrong length,
// bad hex digit); param_value is zero unless the status is ok. A payload longer
// than C_MAX_PAYLOAD characters drops the frame silently. Rate: one character per
// clock, sustained. Each character is first registered in the input register; the
// parse step then updates the frame state and loads the result register, which
// presents the result word for its '#' on m_axis. The only stall is a held result
// word: while it waits and m_axis_tready is low, the input register holds and
// s_axis_tready follows m_axis_tready.
module focuser_command_frame_parser_core
    import fcfp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input characters
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] in_byte
    // result words
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [C_TDATA_W-1:0] m_axis_tdata   // [3:0] cmd_code, [19:4] param_value,
                                                // [21:20] frame_status, [23:22] zero
);

    // parse phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_OP1  = 2'd1;
    localparam logic [1:0] PH_OP2  = 2'd2;
    localparam logic [1:0] PH_PAY  = 2'd3;

    // input register
    logic   r_in_valid;
    t_byte  r_in_byte;

    // frame state
    logic [1:0] r_phase,    n_phase;
    t_byte      r_op1,      n_op1;
    t_code      r_cmd,      n_cmd;
    t_count     r_count,    n_count;
    t_value     r_accum,    n_accum;
    logic       r_all_hex,  n_all_hex;

    // result register
    logic    r_out_valid;
    t_code   r_out_code,   n_out_code;
    t_value  r_out_value,  n_out_value;
    t_status r_out_status, n_out_status;
    logic    n_emit;

    logic       advance;
    logic [4:0] hex_v;
    t_count     exp_len;

    // the parse step runs whenever a character is held and the result register can take a word
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    assign hex_v   = hex_value(r_in_byte);
    assign exp_len = expected_len(r_cmd);

    always_comb begin
        n_phase      = r_phase;
        n_op1        = r_op1;
        n_cmd        = r_cmd;
        n_count      = r_count;
        n_accum      = r_accum;
        n_all_hex    = r_all_hex;
        n_emit       = 1'b0;
        n_out_code   = r_cmd;
        n_out_value  = '0;
        n_out_status = C_ST_OK;

        if (r_in_byte == C_CH_START) begin
            // start of frame, clears whatever was in progress
            n_phase   = PH_OP1;
            n_cmd     = C_CMD_UNREC;
            n_count   = '0;
            n_accum   = '0;
            n_all_hex = 1'b1;
        end else begin
            case (r_phase)
                PH_OP1: begin
                    n_op1   = r_in_byte;
                    n_phase = PH_OP2;
                end
                PH_OP2: begin
                    n_cmd   = decode_pair(r_op1, r_in_byte);
                    n_phase = PH_PAY;
                end
                PH_PAY: begin
                    if (r_in_byte != C_CH_END) begin
                        if (r_count == t_count'(C_MAX_PAYLOAD)) begin
                            // payload overflow: drop the frame
                            n_phase   = PH_IDLE;
                            n_cmd     = C_CMD_UNREC;
                            n_count   = '0;
                            n_accum   = '0;
                            n_all_hex = 1'b1;
                        end else begin
                            n_count = r_count + t_count'(1);
                            if (hex_v[4]) begin
                                n_all_hex = 1'b0;
                                n_accum   = {r_accum[C_VALUE_W-5:0], 4'h0};
                            end else begin
                                n_accum   = {r_accum[C_VALUE_W-5:0], hex_v[3:0]};
                            end
                        end
                    end else begin
                        // end of frame: status precedence unrec, length, hex
                        n_emit = 1'b1;
                        if (r_cmd == C_CMD_UNREC) begin
                            n_out_status = C_ST_UNREC;
                        end else if (r_count != exp_len) begin
                            n_out_status = C_ST_BAD_LEN;
                        end else if (exp_len != C_LEN_NONE && !r_all_hex) begin
                            n_out_status = C_ST_BAD_HEX;
                        end else begin
                            n_out_status = C_ST_OK;
                            if (exp_len == C_LEN_POS) begin
                                n_out_value = r_accum;
                            end else if (exp_len == C_LEN_SPEED) begin
                                n_out_value = {8'h00, r_accum[7:0]};
                            end
                        end
                        n_phase   = PH_IDLE;
                        n_cmd     = C_CMD_UNREC;
                        n_count   = '0;
                        n_accum   = '0;
                        n_all_hex = 1'b1;
                    end
                end
                default: begin
                    // idle: non-start characters are ignored
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_cmd     <= C_CMD_UNREC;
            r_count   <= '0;
            r_accum   <= '0;
            r_all_hex <= 1'b1;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_cmd     <= n_cmd;
            r_count   <= n_count;
            r_accum   <= n_accum;
            r_all_hex <= n_all_hex;
        end
        if (advance) begin
            r_op1 <= n_op1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_emit) begin
            r_out_code   <= n_out_code;
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(C_TDATA_W - C_RES_W)'(0), r_out_status, r_out_value, r_out_code};

    // a failed frame never carries a value
    a_fail_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != C_ST_OK) |-> (r_out_value == '0))
        else $error("nonzero value on failed frame");

    // unrecognized status goes with the unrecognized code and only with it
    a_unrec_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_code == C_CMD_UNREC) == (r_out_status == C_ST_UNREC)))
        else $error("status and code disagree on unrecognized opcode");

    // payload count never passes its limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(C_MAX_PAYLOAD))
        else $error("payload count overflow");

    // a start character always lands in the first opcode phase
    a_start_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_byte == C_CH_START) |=> (r_phase == PH_OP1 && r_count == '0))
        else $error("start character did not restart the frame");

    // reset leaves the parser idle with nothing pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_phase == PH_IDLE && !r_out_valid && !r_in_valid))
        else $error("parser not idle after reset");

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking bench for focuser_command_frame_parser_core
// depends on fcfp_pkg and the core; streams characters in, predicts each result word
// and compares it field by field as it leaves the core
module tb_top
    import fcfp_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on either side
    localparam int END_TAIL       = 8;     // idle clocks after the last result word has left

    typedef enum logic [1:0] {PH_IDLE, PH_OP1, PH_OP2, PH_PAY} t_phase;

    typedef struct packed {
        t_code   code;
        t_value  value;
        t_status status;
    } t_frame;

    // ---------------------------------------------------------------- dut ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [C_TDATA_W-1:0] m_axis_tdata;           // [3:0] cmd_code, [19:4] param_value,
                                                  // [21:20] frame_status, [23:22] zero

    focuser_command_frame_parser_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- parser model state
    t_phase  frame_phase = PH_IDLE;
    t_byte   opcode_lead = 8'h00;
    t_code   frame_cmd   = C_CMD_UNREC;
    int      digit_count = 0;
    t_value  digit_accum = '0;
    logic    digits_hex  = 1'b1;

    t_frame  frames_due[$];        // results owed by the core, oldest first

    // bookkeeping
    int      err_count   = 0;
    int      chars_sent  = 0;
    int      status_count[4] = '{0, 0, 0, 0};
    int      overflow_drops = 0;
    int      idle_cycles = 0;

    // sender and receiver pacing
    logic    tx_idle_en   = 1'b1;
    int      burst_left   = 0;
    logic    rx_stall_en  = 1'b1;
    int      rx_max_stall = 6;
    int      rx_max_ready = 12;
    int      rx_left      = 0;

    // every opcode pair the core knows, in command code order
    logic [15:0] opcode_pairs [0:14] = '{
        "FQ", "GP", "SP", "GN", "SN", "FG", "GH", "SF", "SH", "GI", "GV", "GD", "SD", "GT", "GC"
    };
    string hex_digits = "0123456789ABCDEFabcdef";

    // ---------------------------------------------------------------- prediction
    function automatic t_code opcode_code(input t_byte a, input t_byte b);
        case ({a, b})
            "FQ": return C_CMD_FQ;
            "GP": return C_CMD_GP;
            "SP": return C_CMD_SP;
            "GN": return C_CMD_GN;
            "SN": return C_CMD_SN;
            "FG": return C_CMD_FG;
            "GH": return C_CMD_GH;
            "SF": return C_CMD_SF;
            "SH": return C_CMD_SH;
            "GI": return C_CMD_GI;
            "GV": return C_CMD_GV;
            "GD": return C_CMD_GD;
            "SD": return C_CMD_SD;
            "GT": return C_CMD_GT;
            "GC": return C_CMD_GC;
            default: return C_CMD_UNREC;
        endcase
    endfunction

    // digits a command carries: four for positions, two for speed, none otherwise
    function automatic int payload_len(input t_code code);
        if (code == C_CMD_SP || code == C_CMD_SN) begin
            return 4;
        end else if (code == C_CMD_SD) begin
            return 2;
        end
        return 0;
    endfunction

    // bit 4 flags a character that is no hex digit
    function automatic logic [4:0] hex_nibble(input t_byte c);
        t_byte d;
        if (c >= "0" && c <= "9") begin
            d = c - "0";
        end else if (c >= "A" && c <= "F") begin
            d = c - "A" + 8'd10;
        end else if (c >= "a" && c <= "f") begin
            d = c - "a" + 8'd10;
        end else begin
            return 5'h10;
        end
        return {1'b0, d[3:0]};
    endfunction

    task automatic clear_frame();
        frame_phase = PH_IDLE;
        frame_cmd   = C_CMD_UNREC;
        digit_count = 0;
        digit_accum = '0;
        digits_hex  = 1'b1;
    endtask

    // advance the frame state by one accepted character, queue a result on '#'
    task automatic track_char(input t_byte c);
        t_frame      res;
        logic [4:0]  nib;
        int          want_len;
        if (c == C_CH_START) begin
            clear_frame();
            frame_phase = PH_OP1;
        end else begin
            case (frame_phase)
                PH_OP1: begin
                    opcode_lead = c;
                    frame_phase = PH_OP2;
                end
                PH_OP2: begin
                    frame_cmd   = opcode_code(opcode_lead, c);
                    frame_phase = PH_PAY;
                end
                PH_PAY: begin
                    if (c != C_CH_END) begin
                        if (digit_count == C_MAX_PAYLOAD) begin
                            // one digit too many: frame dropped without a word
                            clear_frame();
                            overflow_drops++;
                        end else begin
                            nib = hex_nibble(c);
                            digit_count++;
                            if (nib[4]) begin
                                digits_hex = 1'b0;
                                nib = 5'h00;
                            end
                            digit_accum = {digit_accum[C_VALUE_W-5:0], nib[3:0]};
                        end
                    end else begin
                        want_len  = payload_len(frame_cmd);
                        res.code  = frame_cmd;
                        res.value = '0;
                        // precedence: opcode, then length, then hex digits
                        if (frame_cmd == C_CMD_UNREC) begin
                            res.status = C_ST_UNREC;
                        end else if (digit_count != want_len) begin
                            res.status = C_ST_BAD_LEN;
                        end else if (want_len > 0 && !digits_hex) begin
                            res.status = C_ST_BAD_HEX;
                        end else begin
                            res.status = C_ST_OK;
                            if (want_len == 4) begin
                                res.value = digit_accum;
                            end else if (want_len == 2) begin
                                res.value = {8'h00, digit_accum[7:0]};
                            end
                        end
                        frames_due = {frames_due, res};
                        status_count[res.status]++;
                        clear_frame();
                    end
                end
                default: ;  // idle: anything but ':' is dropped
            endcase
        end
    endtask

    // ---------------------------------------------------------------- checking
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s at %0t: got %0h, expected %0h", what, $time, got, want);
        err_count++;
    endtask

    t_frame want_frame;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_char(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (frames_due.size() == 0) begin
                    report_mismatch("result word with none due", int'(m_axis_tdata), 0);
                end else begin
                    want_frame = frames_due.pop_front();
                    if (m_axis_tdata[C_CODE_W-1:0] != want_frame.code) begin
                        report_mismatch("cmd_code", int'(m_axis_tdata[C_CODE_W-1:0]),
                                        int'(want_frame.code));
                    end
                    if (m_axis_tdata[C_CODE_W +: C_VALUE_W] != want_frame.value) begin
                        report_mismatch("param_value",
                                        int'(m_axis_tdata[C_CODE_W +: C_VALUE_W]),
                                        int'(want_frame.value));
                    end
                    if (m_axis_tdata[C_CODE_W+C_VALUE_W +: C_STATUS_W] != want_frame.status) begin
                        report_mismatch("frame_status",
                                        int'(m_axis_tdata[C_CODE_W+C_VALUE_W +: C_STATUS_W]),
                                        int'(want_frame.status));
                    end
                end
            end
            // watchdog on handshake progress
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- receiver stalls
    // alternating stretches of ready and stall with random lengths
    always @(posedge i_clk) begin
        if (!rx_stall_en) begin
            m_axis_tready <= 1'b1;
        end else if (rx_left != 0) begin
            rx_left--;
        end else begin
            m_axis_tready <= !m_axis_tready;
            rx_left = m_axis_tready ? $urandom_range(0, rx_max_stall - 1)
                                    : $urandom_range(0, rx_max_ready - 1);
        end
    end

    // ---------------------------------------------------------------- sender
    // one character per call; bursts of random length with idle gaps between them when tx_idle_en is set
    task automatic send_char(input t_byte c);
        if (tx_idle_en && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (burst_left > 0) burst_left--;
        chars_sent++;
    endtask

    task automatic send_frame(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i]);
        end
    endtask

    // hold the input idle until every owed result word has left the core
    task automatic wait_frames_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (frames_due.size() != 0) @(posedge i_clk);
    endtask

    // mostly well-formed frames with random content, some noise and broken frames
    task automatic send_random_frame();
        t_byte  lead;
        t_byte  tail;
        logic [15:0] pair;
        int     n_digits;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) send_char(t_byte'($urandom_range(0, 255)));
        end
        send_char(C_CH_START);
        if ($urandom_range(0, 99) < 85) begin
            pair = opcode_pairs[$urandom_range(0, 14)];
            lead = pair[15:8];
            tail = pair[7:0];
        end else begin
            lead = t_byte'($urandom_range(0, 255));
            tail = t_byte'($urandom_range(0, 255));
        end
        send_char(lead);
        send_char(tail);
        if ($urandom_range(0, 99) < 75) begin
            n_digits = payload_len(opcode_code(lead, tail));
        end else begin
            n_digits = $urandom_range(0, C_MAX_PAYLOAD + 3);  // reaches the overflow drop
        end
        repeat (n_digits) begin
            if ($urandom_range(0, 99) < 90) begin
                send_char(hex_digits[$urandom_range(0, hex_digits.len() - 1)]);
            end else begin
                send_char(t_byte'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 99) < 92) begin
            send_char(C_CH_END);
        end
    endtask

    // ---------------------------------------------------------------- tests
    // every opcode with a well-formed payload, digit extremes and lower case
    task automatic test_opcode_table();
        send_frame(":FQ#");
        send_frame(":GP#");
        send_frame(":SP0000#");
        send_frame(":GN#");
        send_frame(":SNFFFF#");
        send_frame(":FG#");
        send_frame(":GH#");
        send_frame(":SF#");
        send_frame(":SH#");
        send_frame(":GI#");
        send_frame(":GV#");
        send_frame(":GD#");
        send_frame(":SDa5#");
        send_frame(":GT#");
        send_frame(":GC#");
        send_frame(":SP8c3E#");
        wait_frames_drained();
    endtask

    // status precedence, restart, noise, '#' as opcode character and overflow
    task automatic test_frame_errors();
        send_frame(":XY#");                      // unknown opcode
        send_frame(":XY12#");                    // unknown wins over length
        send_frame(":GP7#");                     // digits on a query
        send_frame(":SD123#");                   // speed with three digits
        send_frame(":SP12G4#");                  // bad hex digit
        send_frame(":SDzz#");
        send_frame(":SP12");                     // byte with the top bit set in a payload
        send_char(8'h80);
        send_frame("F#");
        send_frame(":SP12:GV#");                 // ':' restarts mid-payload
        send_char(8'h00);                        // noise while idle
        send_char(8'hFF);
        send_frame("ab#:GD#");
        send_frame(":#Q#");                      // '#' taken as an opcode character
        send_frame(":SN0123456789ABCDEF#");      // longest payload kept, wrong length
        send_frame(":SN0123456789ABCDEF0#");     // one digit over: dropped, '#' ignored
        send_frame(":FQ#");
        wait_frames_drained();
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = chars_sent + 400;
        while (chars_sent < stop_at) send_random_frame();
        wait_frames_drained();
        stop_at = chars_sent + 300;
        while (chars_sent < stop_at) send_random_frame();
        wait_frames_drained();
    endtask

    // no gaps on either side
    task automatic test_back_to_back();
        int stop_at;
        tx_idle_en  = 1'b0;
        rx_stall_en = 1'b0;
        stop_at = chars_sent + 220;
        while (chars_sent < stop_at) send_random_frame();
        wait_frames_drained();
        tx_idle_en  = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // long receiver stalls so held result words push back on the input
    task automatic test_heavy_stall();
        int stop_at;
        tx_idle_en   = 1'b0;
        rx_max_stall = 16;
        rx_max_ready = 3;
        stop_at = chars_sent + 250;
        while (chars_sent < stop_at) send_random_frame();
        wait_frames_drained();
        tx_idle_en   = 1'b1;
        rx_max_stall = 6;
        rx_max_ready = 12;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_opcode_table();
        test_frame_errors();
        test_random_traffic();
        test_back_to_back();
        test_heavy_stall();

        wait_frames_drained();
        repeat (END_TAIL) @(posedge i_clk);

        $display("sent %0d chars; frames ok %0d, unknown %0d, bad length %0d, bad hex %0d",
                 chars_sent, status_count[0], status_count[1], status_count[2], status_count[3]);
        $display("%0d frames dropped on payload overflow, %0d mismatches",
                 overflow_drops, err_count);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
